[rtl/fat16_chain_engine_top_macros.svh]
// assertion macros for the fat16 chain engine
// used by fat16_chain_engine_top; expects a clock named clk and a reset named rst
`ifndef FAT16_CHAIN_ENGINE_TOP_MACROS_SVH
`define FAT16_CHAIN_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define FCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fce_pkg.sv]
// shared types and constants of the fat16 chain engine
// no dependencies; used by fce_table and fat16_chain_engine_top
`timescale 1ns / 1ps

package fce_pkg;

  // field widths
  localparam int CFG_W     = 13;
  localparam int CELL_W    = 16;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 32;

  // defaults
  localparam int              ENTRIES_DEF = 4096;
  localparam logic [CFG_W-1:0] CELLS_RESET = 13'd4096;

  // special cell values
  localparam logic [CELL_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [CELL_W-1:0] LAST_DATA = 16'hFFEF;
  localparam logic [CELL_W-1:0] FREE_CELL = 16'h0000;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_FOLLOW = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FREE      = 2'd2,
    ST_BAD_CHAIN = 2'd3
  } status_t;

  // one table access per cycle: either a read or a write
  typedef struct packed {
    logic              we;
    logic              re;
    logic [CELL_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } mem_req_t;

endpackage

[rtl/fce_table.sv]
// allocation table storage: single-port synchronous memory with a registered read
// depends on fce_pkg for the access struct and cell width
`timescale 1ns / 1ps

module fce_table #(
  parameter int ENTRIES = fce_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  fce_pkg::mem_req_t           req,
  output logic [fce_pkg::CELL_W-1:0]  rdata
);

  localparam int AW = $clog2(ENTRIES);

  logic [fce_pkg::CELL_W-1:0] mem [ENTRIES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

[rtl/fat16_chain_engine_top.sv]
// FAT16 chain engine: one command per input transfer (write cell, follow cell,
// count chain, move cell), one result transfer per command. The table lives in a
// single-port memory with one access per cycle, so commands run one at a time:
// a write is one table write, a follow one read, a move a read, an optional relink
// of the predecessor, a write of the target and a clear of the source, and a count
// reads and checks the chain link by link. Refused commands skip the table, a move
// of a free cell stops after its read, and a looping chain stops at the step cap.
// The next command is taken while a result waits at the output.
// Depends on fce_pkg, fce_table and fat16_chain_engine_top_macros.svh.
`timescale 1ns / 1ps
`include "fat16_chain_engine_top_macros.svh"

module fat16_chain_engine_top #(
  parameter int ENTRIES = fce_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cell_req[15:0], value[31:16], dst_cell[47:32], pred_cell[63:48]
  input  logic [fce_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [1:0]                     s_tuser,
  // result output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[1:0], next_cluster[17:2], at_end[18], chain_length[31:19]
  output logic [fce_pkg::M_TDATA_W-1:0]  m_tdata,
  // cells_in_use register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fce_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CW = fce_pkg::CELL_W;
  localparam int LW = fce_pkg::CFG_W;
  // table size as seen by the limit compare, clipped to the register range
  localparam int          ENT_CLIP = (ENTRIES > 8191) ? 8191 : ENTRIES;
  localparam logic [LW-1:0] ENT_LIM = LW'(ENT_CLIP);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FOLLOW_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_MOVE_WAIT,
    S_MOVE_DST,
    S_MOVE_CLR,
    S_DONE
  } state_t;

  state_t state;

  logic [LW-1:0]     cells_in_use;
  logic [LW-1:0]     lim;
  logic [CW-1:0]     lim_ext;

  fce_pkg::cmd_t     item_cmd;
  logic [CW-1:0]     item_req;
  logic [CW-1:0]     item_val;
  logic [CW-1:0]     item_dst;
  logic [CW-1:0]     item_prv;
  logic [CW-1:0]     moved;

  logic [CW-1:0]     walk_cursor;
  logic [LW-1:0]     walk_count;

  fce_pkg::status_t  res_status;
  logic [CW-1:0]     res_next;
  logic              res_end;
  logic [LW-1:0]     res_len;

  fce_pkg::mem_req_t mem_req;
  logic [CW-1:0]     mem_rdata;

  logic req_oob;
  logic move_oob;
  logic walk_capped;

  // effective limit and range checks
  assign lim         = (cells_in_use < ENT_LIM) ? cells_in_use : ENT_LIM;
  assign lim_ext     = CW'(lim);
  assign req_oob     = (item_req >= lim_ext);
  assign move_oob    = (item_dst >= lim_ext) || (item_dst > fce_pkg::LAST_DATA) || req_oob ||
                       ((item_prv != fce_pkg::FREE_CELL) && (item_prv >= lim_ext));
  assign walk_capped = (walk_count >= lim);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= fce_pkg::CELLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cells_in_use <= cfg_data;
    end
  end

  // table access per state; the sequencer never overlaps two accesses
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = item_val;
    mem_req.addr  = item_req;
    unique case (state)
      S_DISPATCH: begin
        if (!req_oob && item_cmd == fce_pkg::CMD_WRITE) begin
          mem_req.we = 1'b1;
        end
        if (!req_oob && item_cmd == fce_pkg::CMD_FOLLOW) begin
          mem_req.re = 1'b1;
        end
        if (item_cmd == fce_pkg::CMD_MOVE && item_dst != item_req && !move_oob) begin
          mem_req.re = 1'b1;
        end
      end
      S_WALK: begin
        mem_req.addr = walk_cursor;
        mem_req.re   = !walk_capped;
      end
      S_MOVE_WAIT: begin
        // relink the predecessor to the new index
        mem_req.addr  = item_prv;
        mem_req.wdata = item_dst;
        mem_req.we    = (mem_rdata != fce_pkg::FREE_CELL) && (item_prv != fce_pkg::FREE_CELL);
      end
      S_MOVE_DST: begin
        mem_req.addr  = item_dst;
        mem_req.wdata = moved;
        mem_req.we    = 1'b1;
      end
      S_MOVE_CLR: begin
        mem_req.wdata = fce_pkg::FREE_CELL;
        mem_req.we    = 1'b1;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  fce_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // command sequencer with item, walk and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      walk_cursor <= '0;
      walk_count  <= '0;
    end else begin
      // the done state reloads the output itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_cmd <= fce_pkg::cmd_t'(s_tuser);
            item_req <= s_tdata[15:0];
            item_val <= s_tdata[31:16];
            item_dst <= s_tdata[47:32];
            item_prv <= s_tdata[63:48];
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_next <= '0;
          res_end  <= 1'b0;
          res_len  <= '0;
          unique case (item_cmd)
            fce_pkg::CMD_WRITE: begin
              if (req_oob) begin
                res_status <= fce_pkg::ST_RANGE;
              end else begin
                res_status <= fce_pkg::ST_OK;
              end
              state <= S_DONE;
            end
            fce_pkg::CMD_FOLLOW: begin
              if (req_oob) begin
                res_status <= fce_pkg::ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= fce_pkg::ST_OK;
                state      <= S_FOLLOW_WAIT;
              end
            end
            fce_pkg::CMD_COUNT: begin
              if (item_req == fce_pkg::FREE_CELL) begin
                res_status <= fce_pkg::ST_OK;
                state      <= S_DONE;
              end else if (req_oob) begin
                res_status <= fce_pkg::ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status  <= fce_pkg::ST_OK;
                walk_cursor <= item_req;
                walk_count  <= '0;
                state       <= S_WALK;
              end
            end
            fce_pkg::CMD_MOVE: begin
              if (item_dst == item_req) begin
                res_status <= fce_pkg::ST_OK;
                state      <= S_DONE;
              end else if (move_oob) begin
                res_status <= fce_pkg::ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= fce_pkg::ST_OK;
                state      <= S_MOVE_WAIT;
              end
            end
            default: begin
              res_status <= fce_pkg::ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_FOLLOW_WAIT: begin
          res_next <= mem_rdata;
          res_end  <= (mem_rdata == fce_pkg::END_MARK);
          state    <= S_DONE;
        end
        S_WALK: begin
          if (walk_capped) begin
            // chain longer than the table: looping
            res_status <= fce_pkg::ST_BAD_CHAIN;
            res_len    <= walk_count;
            state      <= S_DONE;
          end else begin
            walk_count <= walk_count + 1'b1;
            state      <= S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          if (mem_rdata == fce_pkg::END_MARK) begin
            res_len <= walk_count;
            state   <= S_DONE;
          end else if (mem_rdata >= lim_ext) begin
            res_status <= fce_pkg::ST_BAD_CHAIN;
            res_len    <= walk_count;
            state      <= S_DONE;
          end else begin
            walk_cursor <= mem_rdata;
            state       <= S_WALK;
          end
        end
        S_MOVE_WAIT: begin
          moved <= mem_rdata;
          if (mem_rdata == fce_pkg::FREE_CELL) begin
            res_status <= fce_pkg::ST_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_MOVE_DST;
          end
        end
        S_MOVE_DST: begin
          state <= S_MOVE_CLR;
        end
        S_MOVE_CLR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // load the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_len, res_end, res_next, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer and table accesses
  `FCE_ASSERT_NOW(a_single_access, mem_req.we, !mem_req.re, "table read and write in one cycle")
  `FCE_ASSERT_NOW(a_write_in_range, mem_req.we, mem_req.addr < lim_ext, "table write past limit")
  `FCE_ASSERT_NOW(a_walk_bounded, state == S_WALK_WAIT, walk_count <= lim, "walk count past limit")
  `FCE_ASSERT_NEXT(a_move_not_free, state == S_MOVE_WAIT && mem_rdata == fce_pkg::FREE_CELL,
                   state == S_DONE, "move of a free cell went on")

endmodule

[bench/tb_fat16_chain_engine_top.sv]
// self-checking bench for the fat16 chain engine: random command stream with
// an in-bench table model as predictor, random idling on both stream sides
// depends on fce_pkg and fat16_chain_engine_top
`timescale 1ns / 1ps

module tb_fat16_chain_engine_top;

  localparam int ENTRIES = fce_pkg::ENTRIES_DEF;
  localparam int NUM_PHASES = 8;
  localparam int CW = fce_pkg::CELL_W;
  localparam int LW = fce_pkg::CFG_W;

  typedef struct {
    fce_pkg::cmd_t     op;
    logic [CW-1:0]     cell_req;
    logic [CW-1:0]     value;
    logic [CW-1:0]     dst_cell;
    logic [CW-1:0]     pred_cell;
  } fat_cmd_t;

  typedef struct {
    fce_pkg::status_t  status;
    logic [CW-1:0]     next_cluster;
    logic              at_end;
    logic [LW-1:0]     chain_length;
  } fat_result_t;

  typedef struct {
    fat_cmd_t    c;
    fat_result_t r;
  } fat_job_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [fce_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [fce_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [LW-1:0]                 cfg_data = '0;

  // table model: contents, which cells were ever written, register, walk state
  logic [CW-1:0] fat_model [ENTRIES];
  bit            cell_loaded [ENTRIES];
  logic [LW-1:0] model_cells = fce_pkg::CELLS_RESET;
  logic [CW-1:0] model_cursor = '0;
  logic [LW-1:0] model_walked = '0;

  fat_job_t    cmd_backlog [$];
  fat_result_t results_due [$];
  fat_job_t    drv_job;
  int          outstanding = 0;
  int          cmds_made = 0;
  int          results_seen = 0;
  int          errors = 0;
  bit          calm = 1'b0;
  int          src_gap = 0;
  int          src_quiet = 0;
  int          snk_gap = 0;
  int          snk_quiet = 0;
  int          phase_cells [NUM_PHASES] = '{16, 0, 4096, 37, 1, 200, 4095, 64};
  int          phase_cmds [NUM_PHASES] = '{180, 60, 150, 200, 50, 180, 120, 160};

  fat16_chain_engine_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int table_limit();
    return (int'(model_cells) < ENTRIES) ? int'(model_cells) : ENTRIES;
  endfunction

  function automatic fat_cmd_t make_cmd(fce_pkg::cmd_t op, int req, int val, int dst, int prv);
    fat_cmd_t c;
    c.op        = op;
    c.cell_req  = req[CW-1:0];
    c.value     = val[CW-1:0];
    c.dst_cell  = dst[CW-1:0];
    c.pred_cell = prv[CW-1:0];
    return c;
  endfunction

  // mostly in range, sometimes the range edge, the top code or anything
  function automatic int pick_cell(int lim);
    int r;
    r = $urandom_range(0, 7);
    if (lim > 0 && r < 5) return $urandom_range(0, lim - 1);
    if (r == 5) return lim;
    if (r == 6) return 16'hFFFF;
    return $urandom_range(0, 16'hFFFF);
  endfunction

  function automatic int pick_value(int lim);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return fce_pkg::END_MARK;
    if (r == 1 && lim > 0) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 16'hFFFF);
  endfunction

  // first never-written cell that the command would read, or -1
  function automatic int unwritten_read(fat_cmd_t c);
    int lim;
    int cur;
    int n;
    bit done;
    lim = table_limit();
    case (c.op)
      fce_pkg::CMD_FOLLOW: begin
        if (c.cell_req < lim && !cell_loaded[c.cell_req]) return c.cell_req;
      end
      fce_pkg::CMD_MOVE: begin
        if (c.dst_cell != c.cell_req && c.dst_cell < lim &&
            c.dst_cell <= fce_pkg::LAST_DATA && c.cell_req < lim &&
            (c.pred_cell == 0 || c.pred_cell < lim) &&
            !cell_loaded[c.cell_req]) return c.cell_req;
      end
      fce_pkg::CMD_COUNT: begin
        if (c.cell_req != 0 && c.cell_req < lim) begin
          cur = c.cell_req;
          n = 0;
          done = 1'b0;
          while (!done && n < lim) begin
            if (!cell_loaded[cur]) return cur;
            n++;
            if (fat_model[cur] == fce_pkg::END_MARK || fat_model[cur] >= lim) done = 1'b1;
            else cur = fat_model[cur];
          end
        end
      end
      default: ;
    endcase
    return -1;
  endfunction

  // apply one command to the table model and return its result
  function automatic fat_result_t fat_apply(fat_cmd_t c);
    fat_result_t   r;
    int            lim;
    int            cur;
    int            n;
    bit            done;
    logic [CW-1:0] link;
    logic [CW-1:0] moved;
    lim = table_limit();
    r.status       = fce_pkg::ST_OK;
    r.next_cluster = '0;
    r.at_end       = 1'b0;
    r.chain_length = '0;
    case (c.op)
      fce_pkg::CMD_WRITE: begin
        if (c.cell_req >= lim) begin
          r.status = fce_pkg::ST_RANGE;
        end else begin
          fat_model[c.cell_req]   = c.value;
          cell_loaded[c.cell_req] = 1'b1;
        end
      end
      fce_pkg::CMD_FOLLOW: begin
        if (c.cell_req >= lim) begin
          r.status = fce_pkg::ST_RANGE;
        end else begin
          r.next_cluster = fat_model[c.cell_req];
          r.at_end       = (fat_model[c.cell_req] == fce_pkg::END_MARK);
        end
      end
      fce_pkg::CMD_COUNT: begin
        if (c.cell_req == 0) begin
          r.chain_length = '0;
        end else if (c.cell_req >= lim) begin
          r.status = fce_pkg::ST_RANGE;
        end else begin
          cur = c.cell_req;
          n = 0;
          done = 1'b0;
          while (!done) begin
            if (n >= lim) begin
              r.status = fce_pkg::ST_BAD_CHAIN;
              done = 1'b1;
            end else begin
              n++;
              link = fat_model[cur];
              if (link == fce_pkg::END_MARK) begin
                done = 1'b1;
              end else if (link >= lim) begin
                r.status = fce_pkg::ST_BAD_CHAIN;
                done = 1'b1;
              end else begin
                cur = link;
              end
            end
          end
          model_cursor   = cur[CW-1:0];
          model_walked   = n[LW-1:0];
          r.chain_length = n[LW-1:0];
        end
      end
      default: begin
        // move: nothing for a move onto itself, then range checks, then a free source, then up to three writes in order
        if (c.dst_cell != c.cell_req) begin
          if (c.dst_cell >= lim || c.dst_cell > fce_pkg::LAST_DATA || c.cell_req >= lim ||
              (c.pred_cell != 0 && c.pred_cell >= lim)) begin
            r.status = fce_pkg::ST_RANGE;
          end else begin
            moved = fat_model[c.cell_req];
            if (moved == fce_pkg::FREE_CELL) begin
              r.status = fce_pkg::ST_FREE;
            end else begin
              if (c.pred_cell != 0) begin
                fat_model[c.pred_cell]   = c.dst_cell;
                cell_loaded[c.pred_cell] = 1'b1;
              end
              fat_model[c.dst_cell]   = moved;
              cell_loaded[c.dst_cell] = 1'b1;
              fat_model[c.cell_req]   = fce_pkg::FREE_CELL;
              cell_loaded[c.cell_req] = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // reads of never-written cells become a write of that cell instead
  function automatic void queue_cmd(fat_cmd_t c);
    fat_job_t j;
    int       hole;
    hole = unwritten_read(c);
    if (hole >= 0)
      c = make_cmd(fce_pkg::CMD_WRITE, hole, pick_value(table_limit()),
                   $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
    j.c = c;
    j.r = fat_apply(c);
    cmd_backlog.insert(cmd_backlog.size(), j);
    outstanding++;
    cmds_made++;
  endfunction

  function automatic fat_cmd_t noise_cmd(int lim);
    int prv;
    case ($urandom_range(0, 2))
      0:       prv = 0;
      1:       prv = pick_cell(lim);
      default: prv = $urandom_range(0, 16'hFFFF);
    endcase
    return make_cmd(fce_pkg::cmd_t'($urandom_range(0, 3)), pick_cell(lim),
                    $urandom_range(0, 16'hFFFF), pick_cell(lim), prv);
  endfunction

  // build a short chain, then count, follow and relocate part of it
  function automatic int chain_burst(int lim);
    int cells [8];
    int k;
    int i;
    int j;
    int n;
    int tail;
    k = $urandom_range(1, 7);
    n = 0;
    for (i = 0; i < k; i++) cells[i] = $urandom_range(1, lim - 1);
    for (i = 0; i < k - 1; i++) begin
      queue_cmd(make_cmd(fce_pkg::CMD_WRITE, cells[i], cells[i + 1],
                         $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF)));
      n++;
    end
    // chain end: end mark, a loop back (small tables only) or a bad link
    case ($urandom_range(0, 9))
      7:       tail = (lim <= 256) ? cells[$urandom_range(0, k - 1)] : fce_pkg::END_MARK;
      8, 9:    tail = $urandom_range(lim, 16'hFFFE);
      default: tail = fce_pkg::END_MARK;
    endcase
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, cells[k - 1], tail, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, cells[0], $urandom_range(0, 16'hFFFF), 0, 0));
    n += 2;
    if ($urandom_range(0, 1) == 1) begin
      queue_cmd(make_cmd(fce_pkg::CMD_FOLLOW, cells[$urandom_range(0, k - 1)], 0, 0, 0));
      n++;
    end
    if ($urandom_range(0, 1) == 1) begin
      j = $urandom_range(0, k - 1);
      queue_cmd(make_cmd(fce_pkg::CMD_MOVE, cells[j], 0, $urandom_range(1, lim - 1),
                         (j > 0) ? cells[j - 1] : 0));
      queue_cmd(make_cmd(fce_pkg::CMD_COUNT, cells[0], 0, 0, 0));
      n += 2;
    end
    return n;
  endfunction

  task automatic wait_drained();
    while (outstanding > 0) @(posedge clk);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) results_due.insert(results_due.size(), drv_job.r);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          drv_job = cmd_backlog.pop_front();
          s_tdata <= {drv_job.c.pred_cell, drv_job.c.dst_cell, drv_job.c.value,
                      drv_job.c.cell_req};
          s_tuser <= drv_job.c.op;
          s_tvalid <= 1'b1;
          if (src_quiet > 0) src_quiet--;
          else if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 13);
          else if ($urandom_range(0, 40) == 0) src_quiet = $urandom_range(20, 80);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    fat_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        outstanding--;
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result transfer with no command waiting: %h", m_tdata);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[17:2] !== want.next_cluster) begin
            $error("next_cluster: expected %h, got %h", want.next_cluster, m_tdata[17:2]);
            errors++;
          end
          if (m_tdata[18] !== want.at_end) begin
            $error("at_end: expected %0d, got %0d", want.at_end, m_tdata[18]);
            errors++;
          end
          if (m_tdata[31:19] !== want.chain_length) begin
            $error("chain_length: expected %0d, got %0d", want.chain_length,
                   m_tdata[31:19]);
            errors++;
          end
        end
      end
      // receiver stalls
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (snk_quiet > 0) snk_quiet--;
        else if (!calm && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 13);
        else if ($urandom_range(0, 60) == 0) snk_quiet = $urandom_range(20, 80);
      end
    end
  end

  // stimulus: directed commands at the reset setting, then random phases
  initial begin
    int p;
    int lim;
    int made;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // chain 5 -> 6 -> 7 -> end, top cell, writes past the table
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 5, 6, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 6, 7, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 7, fce_pkg::END_MARK, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 4095, fce_pkg::END_MARK, 16'hFFFF, 16'hFFFF));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 4096, 1, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 16'hFFFF, 16'hAAAA, 0, 0));
    // follow: plain link, end mark, out of range
    queue_cmd(make_cmd(fce_pkg::CMD_FOLLOW, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_cmd(make_cmd(fce_pkg::CMD_FOLLOW, 7, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_FOLLOW, 4096, 0, 0, 0));
    // count: start zero, good chain, start out of range, bad link, loop
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 0, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 5, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 16'hFFFF, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 20, 5000, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 20, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_WRITE, 30, 30, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 30, 0, 0, 0));
    // move: relink, free source, onto itself, target and predecessor past the table
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 6, 0, 10, 5));
    queue_cmd(make_cmd(fce_pkg::CMD_COUNT, 5, 0, 0, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 6, 0, 11, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 10, 0, 10, 5));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 10, 0, 16'hFFF0, 5));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 10, 0, 12, 4096));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 4096, 0, 12, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_MOVE, 4095, 0, 4094, 0));
    queue_cmd(make_cmd(fce_pkg::CMD_FOLLOW, 4094, 0, 0, 0));

    for (p = 0; p < NUM_PHASES; p++) begin
      // register writes only with nothing in flight
      wait_drained();
      if (p == NUM_PHASES - 1) calm = 1'b1;
      @(posedge clk);
      cfg_data  <= phase_cells[p][LW-1:0];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      model_cells = phase_cells[p][LW-1:0];
      lim = table_limit();
      made = 0;
      while (made < phase_cmds[p]) begin
        if (lim >= 2 && $urandom_range(0, 99) < 70) begin
          made += chain_burst(lim);
        end else begin
          queue_cmd(noise_cmd(lim));
          made++;
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      errors++;
    end
    $display("ran %0d commands (write, follow, count, move) across %0d table sizes,",
             cmds_made, NUM_PHASES + 1);
    $display("%0d results compared field by field", results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
